>>> rtl/aligned_free_list_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// aligned_free_list_allocator_top_macros.svh
// Assertion shorthands for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define ALIGNED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFLST_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aflst: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define AFLST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aflst: next-cycle check failed");

`endif

>>> rtl/aflst_pkg.sv
// ----------------------------------------------------------------------------
// aflst_pkg
// Shared constants, types and codes of the aligned free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aflst_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_WIDTH  = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef logic [ADDR_WIDTH-1:0] start_t;
  typedef logic [31:0]           size_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam idx_t IDX_LAST = idx_t'(TABLE_DEPTH - 1);

  // request actions
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  // response status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;

  typedef struct packed {
    start_t start;
    size_t  size;
  } entry_t;

  // table port: one write, one registered read per cycle
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_idx;
    logic   wr_en;
    idx_t   wr_idx;
    entry_t wr_entry;
  } tbl_req_t;

  // scan control from the sequencer
  typedef struct packed {
    logic        start;     // clears the candidates
    logic        eval;      // rd entry is valid this cycle
    idx_t        idx;       // index of rd entry
    logic        is_alloc;
    start_t      addr;
    size_t       size;
    logic [31:0] amask;
  } scan_ctl_t;

  // first matches found over one scan
  typedef struct packed {
    logic   hit_found;    // aligned fit (alloc) or merge target (free)
    idx_t   hit_idx;
    start_t hit_start;
    size_t  hit_size;
    logic   pad_found;    // fit once alignment padding is added
    idx_t   pad_idx;
    start_t pad_start;
    size_t  pad_size;
    size_t  pad_val;
    logic   empty_found;
    idx_t   empty_idx;
  } scan_res_t;

  // bytes needed to bring start up to the alignment given by amask
  function automatic size_t pad_of(start_t start, logic [31:0] amask);
    size_t lo;
    lo = size_t'(start);
    return (32'd0 - lo) & amask;
  endfunction

endpackage

`default_nettype wire

>>> rtl/aflst_table.sv
// ----------------------------------------------------------------------------
// aflst_table
// Region table: one synchronous memory of (start, size) entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aflst_table (
  input  wire logic              clk,
  input  wire aflst_pkg::tbl_req_t req,
  output aflst_pkg::entry_t      rd_entry
);

  aflst_pkg::entry_t mem [aflst_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_entry;
    end
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_idx];
    end
  end

endmodule

`default_nettype wire

>>> rtl/aflst_scan.sv
// ----------------------------------------------------------------------------
// aflst_scan
// Checks one table entry per cycle and keeps the first match of each kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aflst_scan (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire aflst_pkg::scan_ctl_t ctl,
  input  wire aflst_pkg::entry_t    rd_entry,
  output aflst_pkg::scan_res_t      res
);

  logic              used;
  logic              aligned_fit;
  logic              padded_fit;
  logic              merges;
  aflst_pkg::size_t  pad;

  always_comb begin
    used        = (rd_entry.start != '0);
    pad         = aflst_pkg::pad_of(rd_entry.start, ctl.amask);
    aligned_fit = used && (rd_entry.size >= ctl.size) &&
                  ((aflst_pkg::size_t'(rd_entry.start) & ctl.amask) == 32'd0);
    // 33-bit compare, padding sum cannot wrap
    padded_fit  = used && ({1'b0, rd_entry.size} >= ({1'b0, ctl.size} + {1'b0, pad}));
    merges      = used &&
                  ((rd_entry.start - aflst_pkg::start_t'(ctl.size)) == ctl.addr);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      res.hit_found   <= 1'b0;
      res.pad_found   <= 1'b0;
      res.empty_found <= 1'b0;
    end else if (ctl.eval) begin
      if (!res.hit_found && (ctl.is_alloc ? aligned_fit : merges)) begin
        res.hit_found <= 1'b1;
        res.hit_idx   <= ctl.idx;
        res.hit_start <= rd_entry.start;
        res.hit_size  <= rd_entry.size;
      end
      if (!res.pad_found && padded_fit) begin
        res.pad_found <= 1'b1;
        res.pad_idx   <= ctl.idx;
        res.pad_start <= rd_entry.start;
        res.pad_size  <= rd_entry.size;
        res.pad_val   <= pad;
      end
      if (!res.empty_found && !used) begin
        res.empty_found <= 1'b1;
        res.empty_idx   <= ctl.idx;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/aligned_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// aligned_free_list_allocator_top
// First-fit free-list allocator with aligned allocation over a region table.
// ----------------------------------------------------------------------------
// One request at a time. After reset all TABLE_DEPTH (128) table entries are
// cleared with in_ready low. Allocate and free each read the whole table once
// through the single read port, one entry per cycle. After the scan a
// successful allocation passes through S_TAKE, and through S_SPLIT first when
// it splits off alignment padding. Init and the unused action skip the scan. A
// finished response sits in the output register, so the next request is
// accepted while it waits for out_ready; that request's response then waits
// in S_RESP until the earlier one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module aligned_free_list_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] address,
  input  wire logic [31:0] size,
  input  wire logic [4:0]  align_log2,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  status,
  output      logic [31:0] alloc_address
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_LAST   = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_SPLIT  = 8'b0010_0000,
    S_TAKE   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t                 state;
  aflst_pkg::idx_t        cnt;
  logic                   accept;

  logic [1:0]             req_action;
  aflst_pkg::start_t      req_addr;
  aflst_pkg::size_t       req_size;
  logic [31:0]            req_amask;

  logic                   rd_vld;
  aflst_pkg::idx_t        rd_idx;

  aflst_pkg::start_t      cur_start;
  aflst_pkg::size_t       cur_size;
  aflst_pkg::idx_t        target;
  aflst_pkg::size_t       take_size;
  aflst_pkg::start_t      take_start;

  logic [1:0]             res_status;
  logic [31:0]            res_addr;

  aflst_pkg::tbl_req_t    tbl;
  aflst_pkg::entry_t      rd_entry;
  aflst_pkg::scan_ctl_t   sctl;
  aflst_pkg::scan_res_t   sres;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // allocation from the front of the current entry; a used-up entry is emptied
  assign take_size  = cur_size - req_size;
  assign take_start = (take_size != '0) ? (cur_start + aflst_pkg::start_t'(req_size)) : '0;

  always_comb begin
    sctl.start    = accept;
    sctl.eval     = rd_vld;
    sctl.idx      = rd_idx;
    sctl.is_alloc = (req_action == aflst_pkg::ACT_ALLOC);
    sctl.addr     = req_addr;
    sctl.size     = req_size;
    sctl.amask    = req_amask;
  end

  // table access; no writes happen while a scan is reading
  always_comb begin
    tbl = '0;
    unique case (state)
      S_CLEAR: begin
        tbl.wr_en  = 1'b1;
        tbl.wr_idx = cnt;
      end
      S_IDLE: begin
        if (accept && action == aflst_pkg::ACT_INIT) begin
          tbl.wr_en          = 1'b1;
          tbl.wr_idx         = '0;
          tbl.wr_entry.start = aflst_pkg::start_t'(address);
          tbl.wr_entry.size  = size;
        end
      end
      S_SCAN: begin
        tbl.rd_en  = 1'b1;
        tbl.rd_idx = cnt;
      end
      S_DECIDE: begin
        if (req_action == aflst_pkg::ACT_FREE) begin
          if (sres.hit_found) begin
            tbl.wr_en          = 1'b1;
            tbl.wr_idx         = sres.hit_idx;
            tbl.wr_entry.start = req_addr;
            tbl.wr_entry.size  = sres.hit_size + req_size;
          end else if (sres.empty_found) begin
            tbl.wr_en          = 1'b1;
            tbl.wr_idx         = sres.empty_idx;
            tbl.wr_entry.start = req_addr;
            tbl.wr_entry.size  = req_size;
          end
        end
      end
      S_SPLIT: begin
        // the padded entry keeps only its padding
        tbl.wr_en          = 1'b1;
        tbl.wr_idx         = sres.pad_idx;
        tbl.wr_entry.start = sres.pad_start;
        tbl.wr_entry.size  = sres.pad_val;
      end
      S_TAKE: begin
        tbl.wr_en          = 1'b1;
        tbl.wr_idx         = target;
        tbl.wr_entry.start = take_start;
        tbl.wr_entry.size  = take_size;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_vld <= (state == S_SCAN);
    rd_idx <= cnt;

    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + aflst_pkg::idx_t'(1);
          if (cnt == aflst_pkg::IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_action <= action;
            req_addr   <= aflst_pkg::start_t'(address);
            req_size   <= size;
            req_amask  <= (32'd1 << align_log2) - 32'd1;
            res_status <= aflst_pkg::ST_OK;
            res_addr   <= '0;
            cnt        <= '0;
            case (action) inside
              aflst_pkg::ACT_ALLOC, aflst_pkg::ACT_FREE: state <= S_SCAN;
              default:                                   state <= S_RESP;
            endcase
          end
        end
        S_SCAN: begin
          cnt <= cnt + aflst_pkg::idx_t'(1);
          if (cnt == aflst_pkg::IDX_LAST) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          // last read entry is checked this cycle
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_RESP;
          if (req_action == aflst_pkg::ACT_ALLOC) begin
            if (sres.hit_found) begin
              cur_start <= sres.hit_start;
              cur_size  <= sres.hit_size;
              target    <= sres.hit_idx;
              state     <= S_TAKE;
            end else if (sres.pad_found) begin
              if (sres.empty_found) begin
                state <= S_SPLIT;
              end else begin
                res_status <= aflst_pkg::ST_NOSLOT;
              end
            end else begin
              res_status <= aflst_pkg::ST_OOM;
            end
          end else if (!sres.hit_found && !sres.empty_found) begin
            res_status <= aflst_pkg::ST_NOSLOT;
          end
        end
        S_SPLIT: begin
          // aligned remainder moves to the first empty slot
          cur_start <= sres.pad_start + aflst_pkg::start_t'(sres.pad_val);
          cur_size  <= sres.pad_size - sres.pad_val;
          target    <= sres.empty_idx;
          state     <= S_TAKE;
        end
        S_TAKE: begin
          res_addr <= 32'(cur_start);
          state    <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            alloc_address <= res_addr;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  aflst_table u_table (
    .clk      (clk),
    .req      (tbl),
    .rd_entry (rd_entry)
  );

  aflst_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sctl),
    .rd_entry (rd_entry),
    .res      (sres)
  );

endmodule

`default_nettype wire

>>> rtl/aflst_checker.sv
// ----------------------------------------------------------------------------
// aflst_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "aligned_free_list_allocator_top_macros.svh"

module aflst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] alloc_address
);

  // no-slot is the highest status code
  `AFLST_IMPLIES(a_status_code, out_valid, status <= aflst_pkg::ST_NOSLOT)

  // failed allocations report no address
  `AFLST_IMPLIES(a_fail_no_addr, out_valid && (status != aflst_pkg::ST_OK), alloc_address == 32'd0)

  // only one request in flight
  `AFLST_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  `AFLST_NEXT(a_resp_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(alloc_address))

endmodule

bind aligned_free_list_allocator_top aflst_checker u_aflst_checker (.*);

`default_nettype wire

>>> test/aligned_free_list_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_free_list_allocator_top_tb
// Self-checking bench for the aligned first-fit region allocator.
// ----------------------------------------------------------------------------
// A directed table covers the empty pool, zero sizes and addresses, the unused
// action, alignment splits, merges, wrap of starts and sizes, and the padding
// sum at full width. Random traffic follows, mostly allocations and frees of
// blocks handed out earlier, then the region table is filled to exercise the
// table-full paths. Each response is checked against the pool model or a typed reply.
// ----------------------------------------------------------------------------

module aligned_free_list_allocator_top_tb;

  localparam int         TABLE_DEPTH = aflst_pkg::TABLE_DEPTH;
  localparam logic [1:0] ACT_ALLOC   = aflst_pkg::ACT_ALLOC;
  localparam logic [1:0] ACT_FREE    = aflst_pkg::ACT_FREE;
  localparam logic [1:0] ACT_INIT    = aflst_pkg::ACT_INIT;
  localparam logic [1:0] ST_OK       = aflst_pkg::ST_OK;
  localparam logic [1:0] ST_OOM      = aflst_pkg::ST_OOM;
  localparam logic [1:0] ST_NOSLOT   = aflst_pkg::ST_NOSLOT;

  typedef aflst_pkg::start_t start_t;
  typedef aflst_pkg::size_t  size_t;

  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action, must be a no-op

  localparam int N_RANDOM       = 420;
  localparam int N_FILL         = TABLE_DEPTH + 2;
  localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 8;

  typedef struct packed {
    logic [1:0] status;
    start_t     addr;
  } reply_t;

  typedef struct packed {
    logic [1:0] act;
    start_t     addr;
    size_t      sz;
    logic [4:0] ab;
    logic       known;   // reply typed into the table, not taken from the pool model
    reply_t     reply;
  } plan_row_t;

  typedef struct packed {
    start_t addr;
    size_t  sz;
  } block_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_action = ACT_NONE;
  logic [31:0] req_address = '0;
  logic [31:0] req_size = '0;
  logic [4:0]  req_align = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  rsp_status;
  logic [31:0] rsp_addr;

  // pool model
  start_t pool_start [TABLE_DEPTH];
  size_t  pool_size  [TABLE_DEPTH];

  block_t live_q[$];     // blocks handed out and not yet returned
  reply_t expect_q[$];   // replies owed by the block, oldest first

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  n_ok = 0;
  int  n_oom = 0;
  int  n_noslot = 0;
  int  n_split = 0;
  int  n_merge = 0;
  int  stall_cycles = 0;
  bit  calm = 1'b0;

  aligned_free_list_allocator_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (req_action),
    .address       (req_address),
    .size          (req_size),
    .align_log2    (req_align),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (rsp_status),
    .alloc_address (rsp_addr)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int first_free_slot();
    int slot;
    slot = -1;
    for (int k = 0; k < TABLE_DEPTH && slot < 0; k++)
      if (pool_start[k] == '0) slot = k;
    return slot;
  endfunction

  function automatic reply_t carve(size_t sz, logic [4:0] ab);
    logic [32:0] amask;
    logic [32:0] pad;
    logic [32:0] p;
    reply_t      r;
    int          hit;
    int          j;
    r.status = ST_OK;
    r.addr   = '0;
    hit      = -1;
    pad      = '0;
    amask    = (33'd1 << ab) - 33'd1;
    for (int k = 0; k < TABLE_DEPTH && hit < 0; k++)
      if (pool_start[k] != '0 && pool_size[k] >= sz && ({1'b0, pool_start[k]} & amask) == '0)
        hit = k;
    if (hit < 0) begin
      // padded fit, compared at 33 bits so the sum never wraps
      for (int k = 0; k < TABLE_DEPTH && hit < 0; k++) begin
        if (pool_start[k] != '0) begin
          p = ((amask + 33'd1) - ({1'b0, pool_start[k]} & amask)) & amask;
          if ({1'b0, pool_size[k]} >= {1'b0, sz} + p) begin
            hit = k;
            pad = p;
          end
        end
      end
      j = (hit < 0) ? -1 : first_free_slot();
      if (hit < 0) begin
        r.status = ST_OOM;
      end else if (j < 0) begin
        r.status = ST_NOSLOT;
      end else begin
        pool_start[j]  = pool_start[hit] + pad[31:0];
        pool_size[j]   = pool_size[hit] - pad[31:0];
        pool_size[hit] = pad[31:0];
        hit = j;
        n_split++;
      end
    end
    if (r.status == ST_OK) begin
      r.addr = pool_start[hit];
      pool_size[hit] = pool_size[hit] - sz;
      if (pool_size[hit] != '0) pool_start[hit] = pool_start[hit] + sz;
      else pool_start[hit] = '0;
    end
    return r;
  endfunction

  function automatic logic [1:0] give_back(start_t addr, size_t sz);
    int slot;
    slot = -1;
    for (int k = 0; k < TABLE_DEPTH && slot < 0; k++)
      if (pool_start[k] != '0 && start_t'(pool_start[k] - sz) == addr) slot = k;
    if (slot >= 0) begin
      pool_start[slot] = addr;
      pool_size[slot]  = pool_size[slot] + sz;
      n_merge++;
      return ST_OK;
    end
    slot = first_free_slot();
    if (slot < 0) return ST_NOSLOT;
    pool_start[slot] = addr;
    pool_size[slot]  = sz;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(logic [1:0] act, start_t addr, size_t sz,
                                           logic [4:0] ab);
    reply_t r;
    r.status = ST_OK;
    r.addr   = '0;
    case (act)
      ACT_ALLOC: r = carve(sz, ab);
      ACT_FREE:  r.status = give_back(addr, sz);
      ACT_INIT: begin
        pool_start[0] = addr;
        pool_size[0]  = sz;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic [1:0] act, start_t addr, size_t sz,
                                         logic [4:0] ab, logic known, logic [1:0] st,
                                         start_t res);
    plan_row_t q;
    q.act          = act;
    q.addr         = addr;
    q.sz           = sz;
    q.ab           = ab;
    q.known        = known;
    q.reply.status = st;
    q.reply.addr   = res;
    return q;
  endfunction

  // mostly allocations and returns of live blocks, the rest noise
  function automatic plan_row_t pick_request();
    plan_row_t q;
    block_t    b;
    int        roll;
    int        k;
    roll    = $urandom_range(0, 99);
    q.known = 1'b0;
    q.reply = '0;
    q.addr  = $urandom;
    q.sz    = $urandom;
    q.ab    = 5'($urandom_range(0, 31));
    if (roll < 42) begin
      q.act = ACT_ALLOC;
      case ($urandom_range(0, 9)) inside
        [0:4]: q.sz = $urandom_range(1, 1024);
        [5:6]: begin
          k = $urandom_range(0, TABLE_DEPTH - 1);
          q.sz = (pool_start[k] != '0) ? pool_size[k] : 32'h40;
        end
        7: q.sz = '0;
        8: q.sz = $urandom_range(1, 32'h10000);
        default: ;
      endcase
      if ($urandom_range(0, 3) != 0) q.ab = 5'($urandom_range(0, 12));
    end else if (roll < 80) begin
      q.act = ACT_FREE;
      if (live_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        b = live_q[k];
        live_q.delete(k);
        q.addr = b.addr;
        q.sz   = b.sz;
      end
    end else if (roll < 92) begin
      q.act = ACT_INIT;
      if ($urandom_range(0, 3) != 0) begin
        q.addr = $urandom_range(1, 32'hFFFF) << 12;
        q.sz   = $urandom_range(32'h100, 32'h100000);
      end
      if ($urandom_range(0, 15) == 0) q.addr = '0;
    end else begin
      q.act = ACT_NONE;
    end
    return q;
  endfunction

  task automatic issue(input plan_row_t q);
    reply_t r;
    block_t b;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_action  <= q.act;
    req_address <= q.addr;
    req_size    <= q.sz;
    req_align   <= q.ab;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_reply(q.act, q.addr, q.sz, q.ab);
    if (q.act == ACT_ALLOC && r.status == ST_OK && q.sz != '0) begin
      b.addr = r.addr;
      b.sz   = q.sz;
      live_q.push_back(b);
    end
    if (q.known) r = q.reply;
    case (r.status)
      ST_OK:     n_ok++;
      ST_OOM:    n_oom++;
      ST_NOSLOT: n_noslot++;
      default: ;
    endcase
    expect_q.push_back(r);
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      n_recv++;
      if (expect_q.size() == 0) begin
        $display("%0t: response with none pending, status %0d addr %h",
                 $time, rsp_status, rsp_addr);
        n_fail++;
      end else begin
        want = expect_q.pop_front();
        if (rsp_status !== want.status) begin
          $display("%0t: response %0d status expected %0d got %0d",
                   $time, n_recv, want.status, rsp_status);
          n_fail++;
        end
        if (rsp_addr !== want.addr) begin
          $display("%0t: response %0d alloc_address expected %h got %h",
                   $time, n_recv, want.addr, rsp_addr);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    int        idx;
    for (idx = 0; idx < TABLE_DEPTH; idx++) begin
      pool_start[idx] = '0;
      pool_size[idx]  = '0;
    end

    // empty pool, zero address, unused action with every bit set
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h4, 5'd0, 1'b1, ST_OOM, '0));
    plan.push_back(plan_row(ACT_FREE, 32'h0, 32'h0, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1'b1, ST_OK, '0));
    // pool at 0x1000, aligned hit then a padded request that does not fit
    plan.push_back(plan_row(ACT_INIT, 32'h1000, 32'h1000, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h100, 5'd4, 1'b1, ST_OK, 32'h1000));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd12, 1'b1, ST_OOM, '0));
    // split off padding, zero size, merge, entry used up
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd9, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h0, 5'd0, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_FREE, 32'h1000, 32'h100, 5'd0, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h200, 5'd0, 1'b0, ST_OK, '0));
    // size plus padding would wrap at 32 bits
    plan.push_back(plan_row(ACT_INIT, 32'h1, 32'hFFFF_FFFF, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF, 5'd31, 1'b1, ST_OOM, '0));
    // start wraps to zero and leaves the entry empty
    plan.push_back(plan_row(ACT_INIT, 32'hFFFF_FFF0, 32'h100, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd0, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd4, 1'b0, ST_OK, '0));
    // merged size wraps
    plan.push_back(plan_row(ACT_INIT, 32'h2000, 32'hFFFF_FFF0, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_FREE, 32'h1F00, 32'h100, 5'd0, 1'b0, ST_OK, '0));
    // widest alignment
    plan.push_back(plan_row(ACT_INIT, 32'h8000_0000, 32'h10, 5'd0, 1'b1, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd31, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF, 5'd0, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_ALLOC, 32'h0, 32'h0, 5'd31, 1'b0, ST_OK, '0));
    plan.push_back(plan_row(ACT_NONE, 32'h0, 32'h0, 5'd0, 1'b1, ST_OK, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < plan.size(); idx++) issue(plan[idx]);

    for (idx = 0; idx < N_RANDOM; idx++) begin
      calm <= (idx >= 150 && idx < 270);
      issue(pick_request());
    end
    calm <= 1'b0;

    // spaced regions that cannot merge, enough to fill every slot
    for (idx = 0; idx < N_FILL; idx++)
      issue(plan_row(ACT_FREE, 32'h4000_0100 + idx * 32'h1000, 32'h800, 5'd0,
                     1'b0, ST_OK, '0));
    issue(plan_row(ACT_FREE, 32'h7000_0000, 32'h40, 5'd0, 1'b0, ST_OK, '0));
    issue(plan_row(ACT_ALLOC, 32'h0, 32'h10, 5'd9, 1'b0, ST_OK, '0));
    issue(plan_row(ACT_ALLOC, 32'h0, 32'h800, 5'd0, 1'b0, ST_OK, '0));
    issue(plan_row(ACT_FREE, 32'h7000_0000, 32'h40, 5'd0, 1'b0, ST_OK, '0));
    in_valid <= 1'b0;

    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests, %0d responses: %0d ok, %0d out of memory, %0d table full",
             n_sent, n_recv, n_ok, n_oom, n_noslot);
    $display("summary: %0d padding splits, %0d merges, %0d mismatches",
             n_split, n_merge, n_fail);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
